// ===== hdl/brs_pkg.sv =====
// shared types and constants for the biquadratic root solver
package brs_pkg;

  typedef enum logic [1:0] {
    ST_NOT_QUARTIC = 2'd0,
    ST_NO_ROOT     = 2'd1,
    ST_DOUBLE      = 2'd2,
    ST_DISTINCT    = 2'd3
  } status_t;

  localparam int OUT_MAG_W = 32;

endpackage

// ===== hdl/brs_isqrt.sv =====
// pipelined restoring integer square root, one result bit per stage
module brs_isqrt #(
  parameter int IN_W = 32,
  parameter int SIDE_W = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic [IN_W-1:0]       radicand,
  input  logic                  valid_in,
  input  logic [SIDE_W-1:0]     side_in,
  output logic [(IN_W+1)/2-1:0] root,
  output logic                  valid_out,
  output logic [SIDE_W-1:0]     side_out
);
  localparam int RW = (IN_W + 1) / 2;
  localparam int PW = 2 * RW;

  logic [PW-1:0]     rad  [0:RW];
  logic [RW+1:0]     rem  [0:RW];
  logic [RW-1:0]     res  [0:RW];
  logic              vld  [0:RW];
  logic [SIDE_W-1:0] side [0:RW];

  always_comb begin
    rad[0]  = PW'(radicand);
    rem[0]  = '0;
    res[0]  = '0;
    vld[0]  = valid_in;
    side[0] = side_in;
  end

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [RW+1:0] rem_sh;
    logic [RW+1:0] trial;
    logic          fits;
    always_comb begin
      rem_sh = {rem[k][RW-1:0], rad[k][PW-1 -: 2]};
      trial  = {res[k], 2'b01};
      fits   = rem_sh >= trial;
    end
    always_ff @(posedge clk) begin
      if (rst) vld[k+1] <= 1'b0;
      else if (en) vld[k+1] <= vld[k];
      if (en) begin
        rad[k+1]  <= rad[k] << 2;
        rem[k+1]  <= fits ? rem_sh - trial : rem_sh;
        res[k+1]  <= {res[k][RW-2:0], fits};
        side[k+1] <= side[k];
      end
    end
  end

  assign root      = res[RW];
  assign valid_out = vld[RW];
  assign side_out  = side[RW];
endmodule

// ===== hdl/brs_div.sv =====
// pipelined restoring unsigned divider, one quotient bit per stage
module brs_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 16,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic              valid_in,
  input  logic [SIDE_W-1:0] side_in,
  output logic [NUM_W-1:0]  quo,
  output logic              valid_out,
  output logic [SIDE_W-1:0] side_out
);
  logic [NUM_W-1:0]  n    [0:NUM_W];
  logic [DEN_W-1:0]  d    [0:NUM_W];
  logic [DEN_W:0]    rem  [0:NUM_W];
  logic              vld  [0:NUM_W];
  logic [SIDE_W-1:0] side [0:NUM_W];

  always_comb begin
    n[0]    = num;
    d[0]    = den;
    rem[0]  = '0;
    vld[0]  = valid_in;
    side[0] = side_in;
  end

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [DEN_W:0] sh;
    logic           fits;
    always_comb begin
      sh   = {rem[k][DEN_W-1:0], n[k][NUM_W-1]};
      fits = sh >= {1'b0, d[k]};
    end
    always_ff @(posedge clk) begin
      if (rst) vld[k+1] <= 1'b0;
      else if (en) vld[k+1] <= vld[k];
      if (en) begin
        n[k+1]    <= {n[k][NUM_W-2:0], fits};
        d[k+1]    <= d[k];
        rem[k+1]  <= fits ? sh - {1'b0, d[k]} : sh;
        side[k+1] <= side[k];
      end
    end
  end

  assign quo       = n[NUM_W];
  assign valid_out = vld[NUM_W];
  assign side_out  = side[NUM_W];
endmodule

// ===== hdl/biquadratic_root_solver_top.sv =====
// top level of the biquadratic root solver pipeline
// Solves a*x^4 + b*x^2 + c = 0 for real roots, one item per cycle when the
// output is not stalled. The path is: product stage (b*b, a*c),
// discriminant stage, a bit-per-stage square root of delta scaled by
// 2^(2*FRAC_BITS), numerator stage, two bit-per-stage dividers by 2a, two
// bit-per-stage square roots, and an output register. The whole pipeline
// advances whenever the output register is empty or being taken, so a stall
// holds every stage and loses nothing; s_tready is high whenever the pipe
// can move. Status: 0 not quartic, 1 no real root, 2 double root pair,
// 3 distinct roots; each magnitude is unsigned with FRAC_BITS fraction
// bits and saturates at all ones, and its negation is also a root.
module biquadratic_root_solver_top #(
  parameter int COEF_WIDTH = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // coef_a, coef_b, coef_c from bit 0 up, zero filled to bytes
  input  logic [((3*COEF_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status, root_plus_mag, root_plus_valid, root_minus_mag, root_minus_valid
  output logic [71:0] m_tdata
);
  import brs_pkg::*;

  localparam int CW  = COEF_WIDTH;
  localparam int DW  = 2 * CW + 2;          // |delta| width
  localparam int SQW = DW + 2 * FRAC_BITS;  // scaled delta width
  localparam int SW  = (SQW + 1) / 2;       // sqrt(delta) width
  localparam int NW  = (SW > CW + FRAC_BITS ? SW : CW + FRAC_BITS) + 2; // |N|
  localparam int QW  = NW + FRAC_BITS;      // dividend width
  localparam int RW  = (QW + 1) / 2;        // magnitude width
  localparam int MW  = OUT_MAG_W;

  // pipeline advance
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  logic [CW-1:0] in_a, in_b, in_c;
  assign in_a = s_tdata[CW-1:0];
  assign in_b = s_tdata[2*CW-1:CW];
  assign in_c = s_tdata[3*CW-1:2*CW];

  // stage 1: magnitudes and products
  logic          v1, sa1, sb1, sc1, az1;
  logic [CW-1:0] ma1, mb1;
  logic [2*CW-1:0] p1, q1;
  logic [CW-1:0] ma_c, mb_c, mc_c;
  always_comb begin
    ma_c = in_a[CW-1] ? CW'(-in_a) : in_a;
    mb_c = in_b[CW-1] ? CW'(-in_b) : in_b;
    mc_c = in_c[CW-1] ? CW'(-in_c) : in_c;
  end
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= s_tvalid;
    if (en) begin
      sa1 <= in_a[CW-1]; sb1 <= in_b[CW-1]; sc1 <= in_c[CW-1];
      az1 <= (in_a == '0);
      ma1 <= ma_c; mb1 <= mb_c;
      p1  <= mb_c * mb_c;
      q1  <= ma_c * mc_c;
    end
  end

  // stage 2: discriminant
  logic          v2, sa2, sb2, az2, neg2, dz2;
  logic [CW-1:0] ma2, mb2;
  logic [DW-1:0] d2;
  logic [DW-1:0] pe, qe;
  assign pe = DW'(p1);
  assign qe = DW'(q1) << 2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      sa2 <= sa1; sb2 <= sb1; az2 <= az1; ma2 <= ma1; mb2 <= mb1;
      neg2 <= (sa1 == sc1) && (pe < qe);
      d2   <= (sa1 != sc1) ? pe + qe : pe - qe;
      dz2  <= (sa1 != sc1) ? (pe + qe) == '0 : pe == qe;
    end
  end

  // sqrt of delta * 2^(2*FRAC_BITS)
  localparam int S1W = 1 + 1 + 1 + 1 + 1 + 2 * CW;
  logic [S1W-1:0] s1_in, s1_out;
  logic [SW-1:0]  s3;
  logic           v3;
  assign s1_in = {sa2, sb2, az2, neg2, dz2, ma2, mb2};
  brs_isqrt #(.IN_W(SQW), .SIDE_W(S1W)) u_sqd (
    .clk(clk), .rst(rst), .en(en),
    .radicand(SQW'(d2) << (2 * FRAC_BITS)),
    .valid_in(v2), .side_in(s1_in),
    .root(s3), .valid_out(v3), .side_out(s1_out)
  );
  logic sa3, sb3, az3, neg3, dz3;
  logic [CW-1:0] ma3, mb3;
  assign {sa3, sb3, az3, neg3, dz3, ma3, mb3} = s1_out;

  // stage 4: numerators and branch signs
  logic signed [NW-1:0] nb, n1c, n2c;
  always_comb begin
    nb  = sb3 ? $signed(NW'(mb3) << FRAC_BITS) : -$signed(NW'(mb3) << FRAC_BITS);
    n1c = nb + $signed(NW'(s3));
    n2c = nb - $signed(NW'(s3));
  end
  logic v4, az4, neg4, dz4, ok1_4, ok2_4, z1_4, z2_4;
  logic [NW-1:0] nm1_4, nm2_4;
  logic [CW:0]   den4;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
    if (en) begin
      az4 <= az3; neg4 <= neg3; dz4 <= dz3;
      z1_4  <= (n1c == '0);
      z2_4  <= (n2c == '0);
      ok1_4 <= (n1c == '0) || (n1c[NW-1] == sa3);
      ok2_4 <= (n2c == '0) || (n2c[NW-1] == sa3);
      nm1_4 <= n1c[NW-1] ? NW'(-n1c) : NW'(n1c);
      nm2_4 <= n2c[NW-1] ? NW'(-n2c) : NW'(n2c);
      den4  <= {ma3, 1'b0};
    end
  end

  // division by 2a for both branches
  localparam int S2W = 4;
  logic [S2W-1:0] s2_in, s2_out;
  logic           vd1, vd2, ok2_d;
  logic [QW-1:0]  q1o, q2o;
  assign s2_in = {az4, neg4, dz4, ok1_4};
  brs_div #(.NUM_W(QW), .DEN_W(CW+1), .SIDE_W(S2W)) u_div1 (
    .clk(clk), .rst(rst), .en(en), .num(QW'(nm1_4) << FRAC_BITS), .den(den4),
    .valid_in(v4), .side_in(s2_in), .quo(q1o), .valid_out(vd1), .side_out(s2_out)
  );
  brs_div #(.NUM_W(QW), .DEN_W(CW+1), .SIDE_W(1)) u_div2 (
    .clk(clk), .rst(rst), .en(en), .num(QW'(nm2_4) << FRAC_BITS), .den(den4),
    .valid_in(v4), .side_in(ok2_4), .quo(q2o), .valid_out(vd2), .side_out(ok2_d)
  );

  // square roots of both x squared values
  logic [S2W-1:0] s3_out;
  logic           vs1, vs2;
  logic [RW-1:0]  r1, r2;
  logic v5, az5, neg5, dz5, ok1_5, ok2_5;
  brs_isqrt #(.IN_W(QW), .SIDE_W(S2W)) u_sq1 (
    .clk(clk), .rst(rst), .en(en), .radicand(q1o),
    .valid_in(vd1), .side_in(s2_out),
    .root(r1), .valid_out(vs1), .side_out(s3_out)
  );
  brs_isqrt #(.IN_W(QW), .SIDE_W(1)) u_sq2 (
    .clk(clk), .rst(rst), .en(en), .radicand(q2o),
    .valid_in(vd2), .side_in(ok2_d),
    .root(r2), .valid_out(vs2), .side_out(ok2_5)
  );
  assign {az5, neg5, dz5, ok1_5} = s3_out;
  // both branch pipes carry the same valid pattern
  assign v5 = vs1 && vs2;

  // saturate to the output width
  logic [MW-1:0] m1s, m2s;
  always_comb begin
    m1s = (RW > MW && (r1 >> MW) != '0) ? '1 : MW'(r1);
    m2s = (RW > MW && (r2 >> MW) != '0) ? '1 : MW'(r2);
  end

  // output register
  status_t st_next;
  logic    pv_next, mv_next;
  always_comb begin
    pv_next = 1'b0;
    mv_next = 1'b0;
    if (az5) begin
      st_next = ST_NOT_QUARTIC;
    end else if (neg5) begin
      st_next = ST_NO_ROOT;
    end else if (dz5) begin
      pv_next = ok1_5;
      st_next = ok1_5 ? ST_DOUBLE : ST_NO_ROOT;
    end else begin
      pv_next = ok1_5;
      mv_next = ok2_5;
      st_next = (ok1_5 || ok2_5) ? ST_DISTINCT : ST_NO_ROOT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= v5;
    if (en) begin
      m_tdata <= {4'b0000, mv_next, (mv_next ? m2s : MW'(0)), pv_next,
                  (pv_next ? m1s : MW'(0)), st_next};
    end
  end
endmodule

// ===== tb/tb_biquadratic_root_solver_top.sv =====
// testbench for the biquadratic root solver: directed table, then random items
`timescale 1ns / 1ps

module tb_biquadratic_root_solver_top;
  import brs_pkg::*;

  localparam int COEF_WIDTH = 16;
  localparam int FRAC_BITS  = 16;
  localparam int DATA_W     = ((3*COEF_WIDTH+7)/8)*8;
  // drain time: pipeline latency, with margin
  localparam int DRAIN_CYCLES = 5*COEF_WIDTH/2 + 4*FRAC_BITS + 10 + 60;
  localparam int STALL_LIMIT  = 5000;
  localparam int ITEMS_PER_PHASE = 300;
  localparam int MAX_REPORTS  = 10;

  // one result item of the solver
  typedef struct packed {
    status_t     status;
    logic [31:0] plus_mag;
    logic        plus_ok;
    logic [31:0] minus_mag;
    logic        minus_ok;
  } roots_t;

  // one row of the directed table; known says the literal result is to be used
  typedef struct {
    shortint a;
    shortint b;
    shortint c;
    bit      known;
    roots_t  lit;
  } coef_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata = '0;   // coef_a, coef_b, coef_c from bit 0 up
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [71:0]       m_tdata;        // status, plus mag, plus valid, minus mag, minus valid

  roots_t      roots_due[$];
  int unsigned n_errors = 0;
  int unsigned n_sent = 0;
  int unsigned n_got = 0;
  int unsigned n_status[4] = '{0, 0, 0, 0};
  int unsigned idle_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          in_taken, out_taken;

  biquadratic_root_solver_top #(.COEF_WIDTH(COEF_WIDTH), .FRAC_BITS(FRAC_BITS)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // floor square root of a wide unsigned value
  function automatic logic [63:0] floor_sqrt(input logic [127:0] v);
    logic [63:0]  r;
    logic [63:0]  t;
    logic [127:0] sq;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      t = r | (64'd1 << i);
      sq = {64'd0, t} * {64'd0, t};
      if (sq <= v) r = t;
    end
    return r;
  endfunction

  // one root pair: valid when the numerator is zero or has the sign of a
  function automatic bit root_branch(input longint num, input bit a_neg,
                                     input logic [63:0] a_mag, output logic [31:0] mag);
    logic [63:0]  n_mag;
    logic [127:0] xsq;
    logic [63:0]  r;
    mag = '0;
    if (num == 0) return 1'b1;
    if ((num < 0) != a_neg) return 1'b0;
    n_mag = (num < 0) ? -num : num;
    xsq = ({64'd0, n_mag} << FRAC_BITS) / {64'd0, (a_mag << 1)};
    r = floor_sqrt(xsq);
    mag = (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
    return 1'b1;
  endfunction

  function automatic roots_t solve_biquad(input shortint a, input shortint b, input shortint c);
    roots_t      res;
    longint      delta;
    logic [63:0] s;
    longint      nb;
    bit          ok1, ok2;
    logic [31:0] m1, m2;
    res = '0;
    res.status = ST_NOT_QUARTIC;
    if (a == 0) return res;
    delta = longint'(b) * longint'(b) - 4 * longint'(a) * longint'(c);
    if (delta < 0) begin
      res.status = ST_NO_ROOT;
      return res;
    end
    s = floor_sqrt({64'd0, delta} << (2*FRAC_BITS));
    nb = -(longint'(b) <<< FRAC_BITS);
    ok1 = root_branch(nb + longint'(s), a < 0, (a < 0) ? -longint'(a) : longint'(a), m1);
    if (ok1) begin
      res.plus_mag = m1;
      res.plus_ok = 1'b1;
    end
    if (delta == 0) begin
      // double pair: minus branch never reported
      res.status = ok1 ? ST_DOUBLE : ST_NO_ROOT;
      return res;
    end
    ok2 = root_branch(nb - longint'(s), a < 0, (a < 0) ? -longint'(a) : longint'(a), m2);
    if (ok2) begin
      res.minus_mag = m2;
      res.minus_ok = 1'b1;
    end
    res.status = (ok1 || ok2) ? ST_DISTINCT : ST_NO_ROOT;
    return res;
  endfunction

  // offer one item, holding it until the solver takes it; tvalid stays high after
  task automatic send_coefs(input shortint a, input shortint b, input shortint c,
                            input bit known, input roots_t lit);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= DATA_W'({c, b, a});
    do begin
      @(negedge clk);
    end while (!s_tready);
    roots_due.push_back(known ? lit : solve_biquad(a, b, c));
    n_sent++;
    @(posedge clk);
  endtask

  // well-formed root pairs, plus full-range noise, tiny values and zero a
  task automatic random_coefs(output shortint a, output shortint b, output shortint c);
    int kind, r1, r2, ai;
    kind = $urandom_range(99);
    if (kind < 25) begin
      a = shortint'($urandom);
      b = shortint'($urandom);
      c = shortint'($urandom);
    end else if (kind < 30) begin
      a = '0;
      b = shortint'($urandom);
      c = shortint'($urandom);
    end else if (kind < 75) begin
      // a*(x^2-r1)*(x^2-r2) with small integer r1, r2
      do ai = int'($urandom_range(40)) - 20; while (ai == 0);
      r1 = int'($urandom_range(52)) - 12;
      r2 = int'($urandom_range(52)) - 12;
      a = shortint'(ai);
      b = shortint'(-ai * (r1 + r2));
      c = shortint'(ai * r1 * r2);
    end else begin
      a = shortint'(int'($urandom_range(16)) - 8);
      b = shortint'(int'($urandom_range(16)) - 8);
      c = shortint'(int'($urandom_range(16)) - 8);
    end
  endtask

  // receiver stalls at random
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // handshakes are judged at the falling edge, when every signal has settled
  always @(negedge clk) begin
    in_taken = s_tvalid && s_tready;
    out_taken = m_tvalid && m_tready;
    if (out_taken) begin
      roots_t got;
      roots_t want;
      got = '{status: status_t'(m_tdata[1:0]), plus_mag: m_tdata[33:2],
              plus_ok: m_tdata[34], minus_mag: m_tdata[66:35], minus_ok: m_tdata[67]};
      n_got++;
      n_status[m_tdata[1:0]]++;
      if (roots_due.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("[%0t] unexpected result item %h", $realtime, m_tdata);
      end else begin
        want = roots_due.pop_front();
        if (got.status !== want.status || got.plus_mag !== want.plus_mag ||
            got.plus_ok !== want.plus_ok || got.minus_mag !== want.minus_mag ||
            got.minus_ok !== want.minus_ok) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("[%0t] item %0d: expected st=%0d p=%h/%b m=%h/%b, got st=%0d p=%h/%b m=%h/%b",
                     $realtime, n_got, want.status, want.plus_mag, want.plus_ok,
                     want.minus_mag, want.minus_ok, got.status, got.plus_mag,
                     got.plus_ok, got.minus_mag, got.minus_ok);
        end
      end
    end
  end

  // watchdog on cycles where neither side moves an item
  always @(posedge clk) begin
    if (rst || in_taken || out_taken) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout with %0d results outstanding", roots_due.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    coef_row_t rows[$];
    shortint   a, b, c;
    roots_t    lit;

    // literal rows: zero a, negative discriminant, simple known roots
    lit = '0; lit.status = ST_NOT_QUARTIC;
    rows.push_back('{0, 0, 0, 1'b1, lit});
    rows.push_back('{0, -32768, 32767, 1'b1, lit});
    rows.push_back('{0, 32767, -32768, 1'b1, lit});
    lit = '0; lit.status = ST_NO_ROOT;
    rows.push_back('{1, 0, 1, 1'b1, lit});
    rows.push_back('{32767, 0, 32767, 1'b1, lit});
    lit = '0; lit.status = ST_DOUBLE; lit.plus_ok = 1'b1;
    rows.push_back('{1, 0, 0, 1'b1, lit});
    lit = '0; lit.status = ST_DISTINCT;
    lit.plus_mag = 32'h0002_0000; lit.plus_ok = 1'b1;
    lit.minus_mag = 32'h0001_0000; lit.minus_ok = 1'b1;
    rows.push_back('{1, -5, 4, 1'b1, lit});
    lit = '0; lit.status = ST_DISTINCT;
    lit.plus_mag = 32'h0001_0000; lit.plus_ok = 1'b1;
    rows.push_back('{1, 0, -1, 1'b1, lit});
    // the rest through the predictor
    lit = '0;
    rows.push_back('{-1, 2, -1, 1'b0, lit});
    rows.push_back('{1, 1, 0, 1'b0, lit});
    rows.push_back('{1, -2, 1, 1'b0, lit});
    rows.push_back('{32767, -1, 0, 1'b0, lit});
    rows.push_back('{32767, 32767, 32767, 1'b0, lit});
    rows.push_back('{-32768, -32768, -32768, 1'b0, lit});
    rows.push_back('{-32768, 32767, 32767, 1'b0, lit});
    rows.push_back('{32767, -32768, -32768, 1'b0, lit});
    rows.push_back('{1, -32768, 0, 1'b0, lit});
    rows.push_back('{-1, 32767, -32768, 1'b0, lit});
    rows.push_back('{-32768, 0, 32767, 1'b0, lit});
    rows.push_back('{1, -32768, 32767, 1'b0, lit});
    rows.push_back('{-21846, 21845, 21845, 1'b0, lit});

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) send_coefs(rows[i].a, rows[i].b, rows[i].c, rows[i].known, rows[i].lit);
    s_tvalid <= 1'b0;

    // idle phases: none, sender only, receiver only, both
    for (int phase = 0; phase < 4; phase++) begin
      // hold off until the pipe has drained
      while (roots_due.size() != 0) @(posedge clk);
      send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 64 : 19) : 0;
      recv_idle_pct = (phase == 2 || phase == 3) ? ((phase == 2) ? 64 : 19) : 0;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        random_coefs(a, b, c);
        send_coefs(a, b, c, 1'b0, '0);
      end
      s_tvalid <= 1'b0;
    end

    while (roots_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d items under four idle patterns, checked %0d results", n_sent, n_got);
    $display("status mix: not quartic %0d, no root %0d, double %0d, distinct %0d",
             n_status[0], n_status[1], n_status[2], n_status[3]);
    if (n_errors == 0 && roots_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d results missing", n_errors, roots_due.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
